// ===== sv/pngsd_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the PNG stored-deflate encoder.
// No dependencies.
package pngsd_pkg;

    localparam int RAW_W          = 28;
    localparam int HDR_LAST_IDX   = 42;
    localparam int TRAIL_LAST_IDX = 19;
    localparam int BLK_LAST_IDX   = 4;
    localparam int RAW_LAST_IDX   = 3;
    localparam int MAX_RESULTS    = 43;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] IEND_CRC  = 32'hAE426082;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MATH  = 6'b000010,
        ST_HDR   = 6'b000100,
        ST_RAW   = 6'b001000,
        ST_BLK   = 6'b010000,
        ST_TRAIL = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        SEL_HDR   = 2'd0,
        SEL_BLK   = 2'd1,
        SEL_RAW   = 2'd2,
        SEL_TRAIL = 2'd3
    } sel_t;

    typedef struct packed {
        logic       start;
        logic       pixel;
        logic       emit;
        sel_t       sel;
        logic [5:0] idx;
        logic       last_byte;
        logic       load_block;
    } cmd_t;

    typedef struct packed {
        logic in_frame;
        logic col_zero;
        logic item_last;
        logic need_hdr;
        logic math_done;
        logic can_emit;
    } stat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

// ===== sv/pngsd_div.sv =====
// Block-count divider by a constant: reciprocal multiplication over two register stages.
// Used for the stored block count. No package dependencies.
module pngsd_div #(
    parameter int DW      = 29,
    parameter int DIVISOR = 65535
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic [DW-1:0] quotient,
    output logic          busy
);
    localparam int          LG         = $clog2(DIVISOR);
    localparam int          SH         = DW + LG;
    localparam int          PW         = 2 * DW + 1;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [DW:0] RECIP      = RECIP_FULL[DW:0];

    logic [DW-1:0] y_reg;
    logic [PW-1:0] p_reg;
    logic          pend_reg;

    assign quotient = DW'(p_reg >> SH);
    assign busy     = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg <= dividend;
        end
        if (pend_reg) begin
            p_reg <= PW'(y_reg) * PW'(RECIP);
        end
    end
endmodule

// ===== sv/pngsd_ctrl.sv =====
// Sequencer for the encoder: walks the header, raw, block header and trailer byte runs.
// Depends on pngsd_pkg.
module pngsd_ctrl
    import pngsd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  s_tuser,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t     state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic [2:0] blk_reg, blk_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        blk_next   = blk_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        s_tready   = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        cmd.start  = 1'b1;
                        state_next = ST_MATH;
                    end else begin
                        cmd.pixel = 1'b1;
                        if (stat.in_frame) begin
                            state_next = ST_RAW;
                            idx_next   = stat.col_zero ? 6'd0 : 6'd1;
                        end
                    end
                end
            end
            ST_MATH: begin
                if (stat.math_done) begin
                    state_next = ST_HDR;
                    idx_next   = '0;
                end
            end
            ST_HDR: begin
                cmd.sel = SEL_HDR;
                if (stat.can_emit) begin
                    cmd.emit      = 1'b1;
                    cmd.last_byte = idx_reg == 6'(HDR_LAST_IDX);
                    if (idx_reg == 6'(HDR_LAST_IDX)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_RAW: begin
                cmd.sel = SEL_RAW;
                if (stat.need_hdr) begin
                    cmd.load_block = 1'b1;
                    blk_next       = '0;
                    state_next     = ST_BLK;
                end else if (stat.can_emit) begin
                    cmd.emit      = 1'b1;
                    cmd.last_byte = (idx_reg == 6'(RAW_LAST_IDX)) && !stat.item_last;
                    if (idx_reg == 6'(RAW_LAST_IDX)) begin
                        idx_next   = '0;
                        state_next = stat.item_last ? ST_TRAIL : ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_BLK: begin
                cmd.sel = SEL_BLK;
                cmd.idx = {3'd0, blk_reg};
                if (stat.can_emit) begin
                    cmd.emit = 1'b1;
                    if (blk_reg == 3'(BLK_LAST_IDX)) begin
                        state_next = ST_RAW;
                    end else begin
                        blk_next = blk_reg + 1'b1;
                    end
                end
            end
            ST_TRAIL: begin
                cmd.sel = SEL_TRAIL;
                if (stat.can_emit) begin
                    cmd.emit      = 1'b1;
                    cmd.last_byte = idx_reg == 6'(TRAIL_LAST_IDX);
                    if (idx_reg == 6'(TRAIL_LAST_IDX)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            blk_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            blk_reg   <= blk_next;
        end
    end
endmodule

// ===== sv/pngsd_dp.sv =====
// Datapath: config registers, frame counters, byte selection, CRC-32, Adler-32,
// IDAT length math and the output register. Depends on pngsd_pkg and pngsd_div.
module pngsd_dp
    import pngsd_pkg::*;
#(
    parameter int MAX_DIM          = 8192,
    parameter int STORED_BLOCK_MAX = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [13:0] cfg_data,
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,
    input  cmd_t        cmd,
    output stat_t       stat
);
    localparam int DW = RAW_W + 1;

    logic [13:0]      width_reg, height_reg, w_eff, h_eff;
    logic [15:0]      row_len;
    logic [29:0]      prod;
    logic [RAW_W-1:0] raw_reg, raw_left_reg;
    logic [DW-1:0]    quot;
    logic             div_busy, div_start_reg;
    logic [31:0]      idat_len;
    logic             in_frame_reg, last_reg;
    logic [12:0]      col_reg, row_reg;
    logic             col_end, row_end;
    logic [15:0]      block_left_reg, blk_len_reg, blk_len;
    logic             blk_fin_reg;
    logic [15:0]      adler_lo_reg, adler_hi_reg, lo_new, hi_new;
    logic [16:0]      lo_sum, hi_sum;
    logic [31:0]      crc_reg, ihdr_crc_reg;
    logic [23:0]      pix_reg;
    logic [5:0]       n_reg;
    logic             keep, run_end;
    logic [7:0]       b;
    logic             upd_crc, upd_ihdr, upd_raw;
    logic             m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [7:0]       m_tdata_reg;

    always_comb begin
        w_eff = width_reg;
        if (width_reg == '0) w_eff = 14'd1;
        else if (width_reg > 14'(MAX_DIM)) w_eff = 14'(MAX_DIM);
        h_eff = height_reg;
        if (height_reg == '0) h_eff = 14'd1;
        else if (height_reg > 14'(MAX_DIM)) h_eff = 14'(MAX_DIM);
    end

    assign row_len  = 16'd1 + 16'(w_eff) * 16'd3;
    assign prod     = 30'(h_eff) * 30'(row_len);
    assign idat_len = 32'd6 + (32'(quot) << 2) + 32'(quot) + 32'(raw_reg);

    pngsd_div #(.DW(DW), .DIVISOR(STORED_BLOCK_MAX)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (DW'(raw_reg) + DW'(STORED_BLOCK_MAX - 1)),
        .quotient (quot),
        .busy     (div_busy)
    );

    assign col_end = ({1'b0, col_reg} + 14'd1) >= w_eff;
    assign row_end = ({1'b0, row_reg} + 14'd1) >= h_eff;
    assign blk_len = (raw_left_reg > RAW_W'(STORED_BLOCK_MAX)) ? 16'(STORED_BLOCK_MAX)
                                                               : raw_left_reg[15:0];

    assign cfg_ready      = 1'b1;
    assign stat.in_frame  = in_frame_reg;
    assign stat.col_zero  = col_reg == '0;
    assign stat.item_last = last_reg;
    assign stat.need_hdr  = (block_left_reg == '0) && (raw_left_reg != '0);
    assign stat.math_done = !div_start_reg && !div_busy;
    assign stat.can_emit  = !m_tvalid_reg || m_tready;

    // byte source and which checksums it feeds
    always_comb begin
        b        = 8'h00;
        upd_crc  = 1'b0;
        upd_ihdr = 1'b0;
        upd_raw  = 1'b0;
        case (cmd.sel)
            SEL_HDR: begin
                upd_crc  = cmd.idx >= 6'd37;
                upd_ihdr = (cmd.idx >= 6'd12) && (cmd.idx <= 6'd28);
                case (cmd.idx)
                    6'd0:  b = 8'h89;
                    6'd1:  b = 8'h50;
                    6'd2:  b = 8'h4E;
                    6'd3:  b = 8'h47;
                    6'd4:  b = 8'h0D;
                    6'd5:  b = 8'h0A;
                    6'd6:  b = 8'h1A;
                    6'd7:  b = 8'h0A;
                    6'd11: b = 8'h0D;
                    6'd12: b = 8'h49;
                    6'd13: b = 8'h48;
                    6'd14: b = 8'h44;
                    6'd15: b = 8'h52;
                    6'd18: b = {2'b00, w_eff[13:8]};
                    6'd19: b = w_eff[7:0];
                    6'd22: b = {2'b00, h_eff[13:8]};
                    6'd23: b = h_eff[7:0];
                    6'd24: b = 8'h08;
                    6'd25: b = 8'h02;
                    6'd29, 6'd30, 6'd31, 6'd32: b = be_byte(~ihdr_crc_reg, cmd.idx[1:0] - 2'd1);
                    6'd33, 6'd34, 6'd35, 6'd36: b = be_byte(idat_len, cmd.idx[1:0] - 2'd1);
                    6'd37: b = 8'h49;
                    6'd38: b = 8'h44;
                    6'd39: b = 8'h41;
                    6'd40: b = 8'h54;
                    6'd41: b = 8'h78;
                    6'd42: b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
            SEL_BLK: begin
                upd_crc = 1'b1;
                case (cmd.idx[2:0])
                    3'd0:    b = {7'd0, blk_fin_reg};
                    3'd1:    b = blk_len_reg[7:0];
                    3'd2:    b = blk_len_reg[15:8];
                    3'd3:    b = ~blk_len_reg[7:0];
                    default: b = ~blk_len_reg[15:8];
                endcase
            end
            SEL_RAW: begin
                upd_crc = 1'b1;
                upd_raw = 1'b1;
                case (cmd.idx[1:0])
                    2'd0:    b = 8'h00;
                    2'd1:    b = pix_reg[23:16];
                    2'd2:    b = pix_reg[15:8];
                    default: b = pix_reg[7:0];
                endcase
            end
            default: begin
                upd_crc = cmd.idx < 6'd4;
                case (cmd.idx[4:2])
                    3'd0:    b = be_byte({adler_hi_reg, adler_lo_reg}, cmd.idx[1:0]);
                    3'd1:    b = be_byte(~crc_reg, cmd.idx[1:0]);
                    3'd3:    b = be_byte(32'h49454E44, cmd.idx[1:0]);
                    3'd4:    b = be_byte(IEND_CRC, cmd.idx[1:0]);
                    default: b = 8'h00;
                endcase
            end
        endcase
    end

    assign lo_sum  = 17'(adler_lo_reg) + 17'(b);
    assign lo_new  = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum  = 17'(adler_hi_reg) + 17'(lo_new);
    assign hi_new  = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
    assign keep    = n_reg < 6'(MAX_RESULTS);
    assign run_end = cmd.last_byte || (n_reg == 6'(MAX_RESULTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= 14'd1;
            height_reg     <= 14'd1;
            in_frame_reg   <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            block_left_reg <= '0;
            raw_left_reg   <= '0;
            adler_lo_reg   <= 16'd1;
            adler_hi_reg   <= '0;
            crc_reg        <= '1;
            last_reg       <= 1'b0;
            n_reg          <= '0;
            div_start_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            div_start_reg <= cmd.start;
            if (cfg_valid) begin
                if (cfg_addr == CFG_WIDTH) width_reg <= cfg_data;
                if (cfg_addr == CFG_HEIGHT) height_reg <= cfg_data;
            end
            if (cmd.start) begin
                in_frame_reg   <= 1'b1;
                col_reg        <= '0;
                row_reg        <= '0;
                block_left_reg <= '0;
                raw_left_reg   <= prod[RAW_W-1:0];
                adler_lo_reg   <= 16'd1;
                adler_hi_reg   <= '0;
                crc_reg        <= '1;
                last_reg       <= 1'b0;
                n_reg          <= '0;
            end
            if (cmd.pixel && in_frame_reg) begin
                n_reg    <= '0;
                last_reg <= col_end && row_end;
                if (col_end) begin
                    col_reg <= '0;
                    if (row_end) begin
                        row_reg      <= '0;
                        in_frame_reg <= 1'b0;
                    end else begin
                        row_reg <= row_reg + 1'b1;
                    end
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (cmd.load_block) begin
                block_left_reg <= blk_len;
            end
            if (cmd.emit) begin
                if (upd_crc) crc_reg <= crc_byte(crc_reg, b);
                if (upd_raw) begin
                    adler_lo_reg <= lo_new;
                    adler_hi_reg <= hi_new;
                    if (block_left_reg != '0) block_left_reg <= block_left_reg - 1'b1;
                    if (raw_left_reg != '0) raw_left_reg <= raw_left_reg - 1'b1;
                end
                if (keep) n_reg <= n_reg + 1'b1;
            end
            if (cmd.emit && keep) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            raw_reg      <= prod[RAW_W-1:0];
            ihdr_crc_reg <= '1;
        end
        if (cmd.pixel) pix_reg <= s_tdata;
        if (cmd.load_block) begin
            blk_len_reg <= blk_len;
            blk_fin_reg <= raw_left_reg <= RAW_W'(STORED_BLOCK_MAX);
        end
        if (cmd.emit && upd_ihdr) ihdr_crc_reg <= crc_byte(ihdr_crc_reg, b);
        if (cmd.emit && keep) begin
            m_tdata_reg <= b;
            m_tlast_reg <= run_end;
            m_tuser_reg <= run_end && last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg |-> m_tlast_reg)
        else $error("file end without run end");
    a_adler_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (adler_lo_reg < ADLER_MOD[15:0]) && (adler_hi_reg < ADLER_MOD[15:0]))
        else $error("adler sum out of range");
    a_len_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && (cmd.sel == SEL_HDR) |-> stat.math_done)
        else $error("header emitted before length ready");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && keep |-> stat.can_emit)
        else $error("output register overwritten");
endmodule

// ===== sv/png_stored_deflate_encoder.sv =====
// PNG encoder, truecolor 8 bit, uncompressed (stored deflate blocks) in one IDAT chunk.
// A start word (s_tuser=0) emits 43 bytes: signature, IHDR, IDAT length and type, zlib
// header; it first computes the IDAT length (the registered raw size product, then a
// two-stage reciprocal block count). A pixel word (s_tuser=1) emits 3 raw bytes, 4 at a row
// start, plus 5 before each new stored block and 20 trailer bytes after the last pixel, at
// one byte per cycle while m_tready is high; the input is taken again in the cycle after the
// last byte of a word, and the load step before a block header emits no byte. Pixels outside a frame are
// dropped. Depends on pngsd_pkg, pngsd_ctrl, pngsd_dp and pngsd_div.
module png_stored_deflate_encoder
    import pngsd_pkg::*;
#(
    parameter int MAX_DIM          = 8192,
    parameter int STORED_BLOCK_MAX = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [13:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_rgb[23:0]
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // file_end
);
    cmd_t  cmd;
    stat_t stat;

    pngsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pngsd_dp #(.MAX_DIM(MAX_DIM), .STORED_BLOCK_MAX(STORED_BLOCK_MAX)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule
